@@ sv/dcsc_pkg.sv @@
// ----------------------------------------------------------------------------
// dcsc_pkg
// Shared widths, reset values, register indexes and the line store write beat
// for the dark cell stencil counter.
// ----------------------------------------------------------------------------
package dcsc_pkg;

  // Largest image side and the column/row counter width it implies
  localparam int MAX_SIDE = 128;
  localparam int POS_W    = $clog2(MAX_SIDE);
  localparam int SIDE_W   = 8;
  localparam int PIX_W    = 8;
  localparam int COUNT_W  = 14;
  localparam int CFG_IDX_W = 1;

  // Register defaults and the legal floor of the side register
  localparam logic [SIDE_W-1:0] SIDE_RESET   = SIDE_W'(100);
  localparam logic [PIX_W-1:0]  MARGIN_RESET = PIX_W'(50);
  localparam logic [SIDE_W-1:0] SIDE_MIN     = SIDE_W'(3);

  // Saturation ceiling of the abnormal count
  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SIDE_LENGTH     = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_DARKNESS_MARGIN = CFG_IDX_W'(1);

  // One column update of both line stores
  typedef struct packed {
    logic             en;
    logic [POS_W-1:0] col;
    logic [PIX_W-1:0] pix;
  } store_wr_t;

endpackage

@@ sv/dcsc_line_store.sv @@
// ----------------------------------------------------------------------------
// dcsc_line_store
// Two row memories: the row just above the incoming row and the one above
// that. Reads are registered and look one column ahead of the write.
// ----------------------------------------------------------------------------
module dcsc_line_store (
  input  logic                                clk,
  input  logic [dcsc_pkg::POS_W-1:0]          rd_col,
  input  dcsc_pkg::store_wr_t                 wr,
  output logic [dcsc_pkg::PIX_W-1:0]          newer_cur,
  output logic [dcsc_pkg::PIX_W-1:0]          newer_next,
  output logic [dcsc_pkg::PIX_W-1:0]          older_cur
);

  logic [dcsc_pkg::PIX_W-1:0] newer_mem [dcsc_pkg::MAX_SIDE];
  logic [dcsc_pkg::PIX_W-1:0] older_mem [dcsc_pkg::MAX_SIDE];
  logic [dcsc_pkg::POS_W-1:0] rd_col_p1;

  // Column to the right; wraps at the last column, where it is never used
  assign rd_col_p1 = rd_col + dcsc_pkg::POS_W'(1);

  // Shift the column down: the newer row entry moves to the older store.
  // The registered read of the current column already holds that entry.
  always_ff @(posedge clk) begin
    if (wr.en) begin
      older_mem[wr.col] <= newer_cur;
      newer_mem[wr.col] <= wr.pix;
    end
  end

  // Fetch the entries the next cell will need
  always_ff @(posedge clk) begin
    newer_cur  <= newer_mem[rd_col];
    newer_next <= newer_mem[rd_col_p1];
    older_cur  <= older_mem[rd_col];
  end

endmodule

@@ sv/dark_cell_stencil_counter.sv @@
// ----------------------------------------------------------------------------
// dark_cell_stencil_counter
// Counts interior cells of a square grey frame whose left, right, upper and lower
// neighbours are all brighter by at least the darkness margin, and reports the
// count at the end of each frame.
//
//   channel | direction | handshake           | payload
//   in_     | input     | in_valid / in_stall | in_cell_value[7:0]
//   out_    | output    | out_valid/out_stall | out_abnormal_count[13:0]
//   cfg_    | input     | cfg_valid/cfg_ready | cfg_index[0], cfg_wdata[7:0]
//
// One cell per cycle while in_stall is low. The line stores are read into
// registers at the next cell's column, where the position counters go next.
// The stencil decision and count update happen in the accept cycle; a frame count
// shows on out_ the cycle after the frame's last cell.
// Reset clears positions, count and out_valid; line stores are not cleared.
// in_stall is high only while a count waits and out_stall holds it.
// ----------------------------------------------------------------------------
module dark_cell_stencil_counter (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [dcsc_pkg::PIX_W-1:0]        in_cell_value,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [dcsc_pkg::COUNT_W-1:0]      out_abnormal_count,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [dcsc_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [dcsc_pkg::SIDE_W-1:0]       cfg_wdata
);

  localparam int CMP_W = dcsc_pkg::PIX_W + 1;

  // Configuration registers
  logic [dcsc_pkg::SIDE_W-1:0]  side_r;
  logic [dcsc_pkg::PIX_W-1:0]   margin_r;
  logic [dcsc_pkg::SIDE_W-1:0]  side_eff;

  // Position, count and window
  logic [dcsc_pkg::POS_W-1:0]   col_r, col_nxt;
  logic [dcsc_pkg::POS_W-1:0]   row_r, row_nxt;
  logic [dcsc_pkg::COUNT_W-1:0] cnt_r, cnt_nxt;
  logic [dcsc_pkg::PIX_W-1:0]   win_l_r, win_c_r, win_r_r;
  logic [dcsc_pkg::PIX_W-1:0]   win_l_nxt, win_c_nxt, win_r_nxt;

  // Output register
  logic                         out_valid_r;
  logic [dcsc_pkg::COUNT_W-1:0] out_cnt_r;

  // Stencil datapath
  logic                         in_acc;
  logic [dcsc_pkg::SIDE_W-1:0]  col_p1, row_p1;
  logic                         has_right, row_end, frame_end, interior, dark;
  logic [CMP_W-1:0]             thresh;
  logic [dcsc_pkg::PIX_W-1:0]   newer_cur, newer_next, older_cur;
  dcsc_pkg::store_wr_t          st_wr;

  // Take register writes at any time; software must write only while idle, unchecked here
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r   <= dcsc_pkg::SIDE_RESET;
      margin_r <= dcsc_pkg::MARGIN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        dcsc_pkg::REG_SIDE_LENGTH:     side_r   <= cfg_wdata;
        dcsc_pkg::REG_DARKNESS_MARGIN: margin_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Limit the side to the legal range
  always_comb begin
    if (side_r < dcsc_pkg::SIDE_MIN) begin
      side_eff = dcsc_pkg::SIDE_MIN;
    end else if (side_r > dcsc_pkg::SIDE_W'(dcsc_pkg::MAX_SIDE)) begin
      side_eff = dcsc_pkg::SIDE_W'(dcsc_pkg::MAX_SIDE);
    end else begin
      side_eff = side_r;
    end
  end

  // Hold the input only while a finished count is stuck at the output
  assign in_stall = out_valid_r && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // Row and frame boundaries
  assign col_p1    = dcsc_pkg::SIDE_W'(col_r) + dcsc_pkg::SIDE_W'(1);
  assign row_p1    = dcsc_pkg::SIDE_W'(row_r) + dcsc_pkg::SIDE_W'(1);
  assign has_right = col_p1 < side_eff;
  assign row_end   = !has_right;
  assign frame_end = row_end && (row_p1 >= side_eff);
  assign interior  = (row_r >= dcsc_pkg::POS_W'(2)) && (col_r != '0) && has_right;

  // Slide the window along the row above
  always_comb begin
    if (col_r == '0) begin
      win_l_nxt = '0;
      win_c_nxt = newer_cur;
    end else begin
      win_l_nxt = win_c_r;
      win_c_nxt = win_r_r;
    end
    win_r_nxt = has_right ? newer_next : '0;
  end

  // Judge the centre cell against all four neighbours
  assign thresh = CMP_W'(win_c_nxt) + CMP_W'(margin_r);
  assign dark   = (CMP_W'(older_cur)     >= thresh) &&
                  (CMP_W'(in_cell_value) >= thresh) &&
                  (CMP_W'(win_l_nxt)     >= thresh) &&
                  (CMP_W'(win_r_nxt)     >= thresh);

  // Advance position and count
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    cnt_nxt = cnt_r;
    if (in_acc) begin
      if (interior && dark && (cnt_r != dcsc_pkg::COUNT_MAX)) begin
        cnt_nxt = cnt_r + dcsc_pkg::COUNT_W'(1);
      end
      if (frame_end) begin
        col_nxt = '0;
        row_nxt = '0;
        cnt_nxt = '0;
      end else if (row_end) begin
        col_nxt = '0;
        row_nxt = row_p1[dcsc_pkg::POS_W-1:0];
      end else begin
        col_nxt = col_p1[dcsc_pkg::POS_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r <= '0;
      row_r <= '0;
      cnt_r <= '0;
    end else begin
      col_r <= col_nxt;
      row_r <= row_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Window contents are rebuilt from column zero of every row
  always_ff @(posedge clk) begin
    if (in_acc) begin
      win_l_r <= win_l_nxt;
      win_c_r <= win_c_nxt;
      win_r_r <= win_r_nxt;
    end
  end

  // Line stores: read at the next cell's column; the write column never
  // equals a read column at the same edge, so no forwarding is needed
  assign st_wr.en  = in_acc;
  assign st_wr.col = col_r;
  assign st_wr.pix = in_cell_value;

  dcsc_line_store u_store (
    .clk        (clk),
    .rd_col     (col_nxt),
    .wr         (st_wr),
    .newer_cur  (newer_cur),
    .newer_next (newer_next),
    .older_cur  (older_cur)
  );

  // Output beat: load the frame count, drop it once taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc && frame_end) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && frame_end) begin
      out_cnt_r <= cnt_nxt == '0 ? cnt_r + dcsc_pkg::COUNT_W'(interior && dark &&
                   (cnt_r != dcsc_pkg::COUNT_MAX)) : cnt_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_abnormal_count = out_cnt_r;

  // A frame end returns the counters to the frame origin and shows a beat
  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && frame_end |=> out_valid && col_r == '0 && row_r == '0 && cnt_r == '0)
    else $error("frame end did not restart counters");

  // Position only moves on an accepted beat
  a_pos_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !in_acc |=> $stable(col_r) && $stable(row_r) && $stable(cnt_r))
    else $error("position moved without an input beat");

  // A count beat appears only after a frame's last cell
  a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_acc && frame_end))
    else $error("output beat without frame end");

  // Count grows by at most one per cell within a frame
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !frame_end |=> (cnt_r == $past(cnt_r)) ||
                             (cnt_r == $past(cnt_r) + dcsc_pkg::COUNT_W'(1)))
    else $error("count stepped by more than one");

endmodule
